@@ hdl/hwpc_pkg.sv @@
// shared types, codes and blink table for the host watchdog power cycler
`timescale 1ns / 1ps
`default_nettype none

package hwpc_pkg;

    localparam int PATTERN_STEPS = 8;
    localparam int LED_STEP_W    = $clog2(PATTERN_STEPS);
    localparam int LED_CNT_W     = 9;

    localparam logic [6:0] WINDOW_LEN     = 7'd90;
    localparam logic [2:0] MAX_RESTARTS   = 3'd3;
    localparam logic [15:0] GRACE_AT_RST  = 16'd5;

    // status bit positions
    localparam int ST_ACTIVE = 0;
    localparam int ST_REBOOT = 1;
    localparam int ST_OFF    = 2;

    // host commands
    localparam logic [1:0] CMD_NONE      = 2'd0;
    localparam logic [1:0] CMD_BOOT_DONE = 2'd1;
    localparam logic [1:0] CMD_KEEPALIVE = 2'd2;

    // led profile codes
    localparam logic [1:0] PAT_LONG_OFF = 2'd0;
    localparam logic [1:0] PAT_IDLE     = 2'd1;
    localparam logic [1:0] PAT_ARMED    = 2'd2;
    localparam logic [1:0] PAT_REBOOT   = 2'd3;

    // register indexes
    localparam logic [1:0] REG_KEEPALIVE = 2'd0;
    localparam logic [1:0] REG_REBOOT    = 2'd1;
    localparam logic [1:0] REG_LONG_OFF  = 2'd2;
    localparam logic [1:0] REG_GRACE     = 2'd3;

    typedef struct packed {
        logic [7:0]  keepalive_timeout;
        logic [7:0]  reboot_off_time;
        logic [15:0] long_off_time;
        logic [15:0] boot_grace_time;
    } t_cfg;

    typedef struct packed {
        logic       led_tick;
        logic       second_tick;
        logic [1:0] command;
    } t_item;

    typedef struct packed {
        logic flag_powered_off;
        logic flag_rebooting;
        logic flag_active;
        logic led_level;
        logic aux_line_level;
        logic main_power_on;
    } t_result;

    // tick length of one step of a blink profile
    function automatic logic [LED_CNT_W-1:0] blink_len(input logic [1:0] pat,
                                                       input logic [2:0] step);
        logic [LED_CNT_W-1:0] len;
        len = '0;
        unique case (pat)
            PAT_LONG_OFF: len = step[0] ? 9'd500 : 9'd10;
            PAT_IDLE:     len = step[0] ? 9'd99 : 9'd1;
            PAT_ARMED: begin
                unique case (step)
                    3'd0, 3'd2: len = 9'd2;
                    3'd1, 3'd3: len = 9'd10;
                    3'd7:       len = 9'd78;
                    default:    len = 9'd1;
                endcase
            end
            default:      len = 9'd3;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

@@ hdl/host_watchdog_power_cycler.sv @@
// top level: stream input and output registers around the watchdog core
// a transaction is held in the input register, then its result is registered in the output register and offered
// throughput: one transaction per cycle while m_axis_tready does not hold the output register
// while the output register waits on m_axis_tready the input register holds one more
// reset (i_rst_n low, synchronous): both registers empty, power on, grace of
// five seconds running, registers at their documented defaults
`timescale 1ns / 1ps
`default_nettype none

module host_watchdog_power_cycler
    import hwpc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,  // command[1:0], second_tick, led_tick, zeros
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // main_power_on, aux_line_level, led_level, flag_active, flag_rebooting,
    // flag_powered_off, zeros
    output logic      [7:0]  m_axis_tdata,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    t_cfg    cfg;
    t_item   r_in_item;
    logic    r_in_valid;
    t_result core_res;
    t_result r_out_res;
    logic    r_out_valid;
    logic    advance;
    logic    in_acc;

    assign advance       = r_in_valid & (~r_out_valid | m_axis_tready);
    assign s_axis_tready = ~r_in_valid | advance;
    assign in_acc        = s_axis_tvalid & s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_res};

    hwpc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    hwpc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_item   (r_in_item),
        .i_cfg    (cfg),
        .o_result (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc)       r_in_valid <= 1'b1;
            else if (advance) r_in_valid <= 1'b0;
            if (advance)            r_out_valid <= 1'b1;
            else if (m_axis_tready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc)  r_in_item <= t_item'(s_axis_tdata[3:0]);
        if (advance) r_out_res <= core_res;
    end

endmodule

`default_nettype wire

@@ hdl/hwpc_cfg.sv @@
// configuration register file with its apb-style port
`timescale 1ns / 1ps
`default_nettype none

module hwpc_cfg
    import hwpc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output t_cfg             o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[3:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.keepalive_timeout <= 8'd5;
            r_cfg.reboot_off_time   <= 8'd2;
            r_cfg.long_off_time     <= 16'd120;
            r_cfg.boot_grace_time   <= 16'd5;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_KEEPALIVE: r_cfg.keepalive_timeout <= pwdata[7:0];
                REG_REBOOT:    r_cfg.reboot_off_time   <= pwdata[7:0];
                REG_LONG_OFF:  r_cfg.long_off_time     <= pwdata[15:0];
                default:       r_cfg.boot_grace_time   <= pwdata[15:0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_KEEPALIVE: prdata = {24'd0, r_cfg.keepalive_timeout};
            REG_REBOOT:    prdata = {24'd0, r_cfg.reboot_off_time};
            REG_LONG_OFF:  prdata = {16'd0, r_cfg.long_off_time};
            default:       prdata = {16'd0, r_cfg.boot_grace_time};
        endcase
    end

endmodule

`default_nettype wire

@@ hdl/hwpc_core.sv @@
// watchdog state registers and the one-step update for a transaction
`timescale 1ns / 1ps
`default_nettype none

module hwpc_core
    import hwpc_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_step,
    input  wire t_item i_item,
    input  wire t_cfg  i_cfg,
    output t_result    o_result
);

    logic [2:0]            r_st,   n_st;
    logic [7:0]            r_wd,   n_wd;
    logic [7:0]            r_off,  n_off;
    logic [15:0]           r_lo,   n_lo;
    logic [15:0]           r_gr,   n_gr;
    logic [6:0]            r_win,  n_win;
    logic [2:0]            r_rc,   n_rc;
    logic                  r_pw,   n_pw;
    logic                  r_aux,  n_aux;
    logic                  r_ls,   n_ls;
    logic [LED_CNT_W-1:0]  r_lc,   n_lc;
    logic [LED_STEP_W-1:0] r_lstep, n_lstep;
    logic [1:0]            r_lpat, n_lpat;

    always_comb begin
        n_st = r_st;   n_wd = r_wd;   n_off = r_off; n_lo = r_lo;
        n_gr = r_gr;   n_win = r_win; n_rc = r_rc;   n_pw = r_pw;
        n_aux = r_aux; n_ls = r_ls;   n_lc = r_lc;
        n_lstep = r_lstep; n_lpat = r_lpat;

        if (i_item.led_tick) begin
            if (n_lc != '0) n_lc = n_lc - 1'b1;
            if (n_lc == '0) begin
                n_lc = blink_len(n_lpat, 3'(n_lstep));
                n_lstep = (n_lstep == LED_STEP_W'(PATTERN_STEPS - 1)) ? '0
                                                                     : n_lstep + 1'b1;
                n_ls = ~n_ls;
            end
        end

        if (i_item.second_tick) begin
            if (n_wd  != '0) n_wd  = n_wd  - 1'b1;
            if (n_off != '0) n_off = n_off - 1'b1;
            if (n_lo  != '0) n_lo  = n_lo  - 1'b1;
            if (n_gr  != '0) n_gr  = n_gr  - 1'b1;
            if (n_win != '0) n_win = n_win - 1'b1;
            if (n_win == '0 && n_rc < MAX_RESTARTS) n_rc = '0;
        end

        unique case (i_item.command)
            CMD_BOOT_DONE: begin
                n_gr = '0;
                n_wd = i_cfg.keepalive_timeout;
                n_st[ST_ACTIVE] = 1'b1;
                n_ls = 1'b0; n_lstep = '0; n_lpat = PAT_ARMED;
            end
            CMD_KEEPALIVE: n_wd = i_cfg.keepalive_timeout;
            default: ;
        endcase

        // grace over: arm
        if (!n_st[ST_ACTIVE] && n_gr == '0) begin
            n_st[ST_ACTIVE] = 1'b1;
            n_wd = i_cfg.keepalive_timeout;
            n_ls = 1'b0; n_lstep = '0; n_lpat = PAT_ARMED;
        end

        // keepalive expired: cut power
        if (n_st[ST_ACTIVE] && !n_st[ST_REBOOT] && !n_st[ST_OFF] && n_wd == '0) begin
            n_st[ST_REBOOT] = 1'b1;
            n_off = i_cfg.reboot_off_time;
            n_ls = 1'b0; n_lstep = '0; n_lpat = PAT_REBOOT;
            n_pw = 1'b0;
            if (n_rc == '0) begin
                n_win = WINDOW_LEN;
                n_rc  = 3'd1;
            end else begin
                n_rc = n_rc + 1'b1;
                if (n_rc > MAX_RESTARTS) begin
                    n_ls = 1'b0; n_lstep = '0; n_lpat = PAT_LONG_OFF;
                    n_st[ST_OFF]    = 1'b1;
                    n_st[ST_REBOOT] = 1'b0;
                    n_lo = i_cfg.long_off_time;
                    n_rc = '0;
                end
            end
        end

        if (n_st[ST_REBOOT] && n_off == '0) begin
            n_st[ST_REBOOT] = 1'b0;
            n_st[ST_ACTIVE] = 1'b0;
            n_gr = i_cfg.boot_grace_time;
            n_ls = 1'b0; n_lstep = '0; n_lpat = PAT_IDLE;
            n_pw = 1'b1;
            n_aux = ~n_aux;
        end

        if (n_st[ST_OFF] && n_lo == '0) begin
            n_st = '0;
            n_gr = i_cfg.boot_grace_time;
            n_ls = 1'b0; n_lstep = '0; n_lpat = PAT_IDLE;
            n_pw = 1'b1;
        end
    end

    assign o_result.main_power_on    = n_pw;
    assign o_result.aux_line_level   = n_aux;
    assign o_result.led_level        = n_ls;
    assign o_result.flag_active      = n_st[ST_ACTIVE];
    assign o_result.flag_rebooting   = n_st[ST_REBOOT];
    assign o_result.flag_powered_off = n_st[ST_OFF];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;   r_wd <= '0;  r_off <= '0;  r_lo <= '0;
            r_gr <= GRACE_AT_RST; r_win <= '0; r_rc <= '0;
            r_pw <= 1'b1; r_aux <= 1'b0; r_ls <= 1'b0;
            r_lc <= '0;   r_lstep <= '0; r_lpat <= PAT_IDLE;
        end else if (i_step) begin
            r_st <= n_st;   r_wd <= n_wd;   r_off <= n_off; r_lo <= n_lo;
            r_gr <= n_gr;   r_win <= n_win; r_rc <= n_rc;   r_pw <= n_pw;
            r_aux <= n_aux; r_ls <= n_ls;   r_lc <= n_lc;
            r_lstep <= n_lstep; r_lpat <= n_lpat;
        end
    end

endmodule

`default_nettype wire
